// ===== rtl/core/lpc_pkg.sv =====
`timescale 1ns / 1ps

package lpc_pkg;

  // coordinate and derived widths
  localparam int COORD_WIDTH  = 8;
  localparam int ROW_WIDTH    = COORD_WIDTH + 1;
  localparam int ERR_WIDTH    = COORD_WIDTH + 3;
  localparam int HEIGHT_WIDTH = 8;
  localparam int DIFF_WIDTH   = (ROW_WIDTH > HEIGHT_WIDTH + 1) ? ROW_WIDTH : HEIGHT_WIDTH + 1;

  localparam logic [HEIGHT_WIDTH-1:0] HEIGHT_RESET = HEIGHT_WIDTH'(64);

  typedef logic [COORD_WIDTH-1:0]        coord_t;
  typedef logic signed [ERR_WIDTH-1:0]   err_t;
  typedef logic [HEIGHT_WIDTH-1:0]       height_t;
  typedef logic signed [ROW_WIDTH-1:0]   row_t;

  // walk position carried between steps
  typedef struct packed {
    coord_t x;
    coord_t y;
    err_t   err;
  } walk_pos_t;

  // step status back to the sequencer
  typedef struct packed {
    logic hit;
    logic at_end;
  } step_flags_t;

endpackage

// ===== rtl/core/lpc_step.sv =====
`timescale 1ns / 1ps

module lpc_step (
  input  lpc_pkg::walk_pos_t   pos_i,
  input  lpc_pkg::coord_t      end_x_i,
  input  lpc_pkg::coord_t      end_y_i,
  input  lpc_pkg::coord_t      probe_x_i,
  input  lpc_pkg::coord_t      dx_i,
  input  lpc_pkg::coord_t      dy_i,
  input  logic                 sx_neg_i,
  input  logic                 sy_neg_i,
  output lpc_pkg::walk_pos_t   pos_o,
  output lpc_pkg::step_flags_t flags_o
);
  import lpc_pkg::*;

  err_t e2;
  err_t dx_ext;
  err_t dy_ext;
  err_t err_sub;
  logic step_x;
  logic step_y;

  // doubled error against both deltas
  assign dx_ext = $signed({{(ERR_WIDTH-COORD_WIDTH){1'b0}}, dx_i});
  assign dy_ext = $signed({{(ERR_WIDTH-COORD_WIDTH){1'b0}}, dy_i});
  assign e2     = err_t'(pos_i.err <<< 1);
  assign step_x = (e2 > -dy_ext);
  assign step_y = (e2 < dx_ext);

  // termination checks on the current point
  assign flags_o.hit    = (pos_i.x == probe_x_i);
  assign flags_o.at_end = (pos_i.x == end_x_i) && (pos_i.y == end_y_i);

  // next point and error
  assign err_sub = step_x ? (pos_i.err - dy_ext) : pos_i.err;

  always_comb begin
    pos_o.err = step_y ? (err_sub + dx_ext) : err_sub;
    pos_o.x   = pos_i.x;
    pos_o.y   = pos_i.y;
    if (step_x) begin
      pos_o.x = sx_neg_i ? (pos_i.x - COORD_WIDTH'(1)) : (pos_i.x + COORD_WIDTH'(1));
    end
    if (step_y) begin
      pos_o.y = sy_neg_i ? (pos_i.y - COORD_WIDTH'(1)) : (pos_i.y + COORD_WIDTH'(1));
    end
  end

endmodule

// ===== rtl/core/line_point_at_column_unit.sv =====
`timescale 1ns / 1ps

// Finds the point of a line segment in a probe column. Each transfer on the
// input channel gives the segment end points and the probe column; the block
// walks the segment with the Bresenham error rule, one point per clock through
// a single shared step unit, and stops at the first point in the probe column
// (found, its y and display_height minus y) or at the end point (not found,
// zeros). An item is captured in the idle state, then the setup state forms
// the deltas and the initial error, then the walk state visits the points.
// A walk that has stopped holds its last point for as long as the previous
// result still waits in the result register. The input side is ready only
// between items; a finished result sits in an output register, so the next
// item can be taken while the previous result still waits. display_height
// resets to 64; the user must write it through cfg_we_i / cfg_wdata_i only
// while the block is idle, which the block itself does not enforce.
module line_point_at_column_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  lpc_pkg::height_t      cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lpc_pkg::coord_t       start_x_i,
  input  lpc_pkg::coord_t       start_y_i,
  input  lpc_pkg::coord_t       end_x_i,
  input  lpc_pkg::coord_t       end_y_i,
  input  lpc_pkg::coord_t       probe_x_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  found_o,
  output lpc_pkg::coord_t       point_y_o,
  output lpc_pkg::row_t         screen_row_o
);
  import lpc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_WALK
  } state_e;

  state_e      state_q;
  walk_pos_t   pos_q;
  walk_pos_t   pos_next;
  step_flags_t flags;
  coord_t      end_x_q;
  coord_t      end_y_q;
  coord_t      probe_q;
  coord_t      dx_q;
  coord_t      dy_q;
  logic        sx_neg_q;
  logic        sy_neg_q;
  height_t     height_q;
  logic        out_valid_q;
  logic        found_q;
  coord_t      point_y_q;
  row_t        row_q;

  coord_t                 dx_calc;
  coord_t                 dy_calc;
  err_t                   err_init;
  logic                   out_free;
  logic                   walk_done;
  logic                   result_load;
  logic [DIFF_WIDTH-1:0]  row_diff;

  // shared step unit
  lpc_step u_step (
    .pos_i     (pos_q),
    .end_x_i   (end_x_q),
    .end_y_i   (end_y_q),
    .probe_x_i (probe_q),
    .dx_i      (dx_q),
    .dy_i      (dy_q),
    .sx_neg_i  (sx_neg_q),
    .sy_neg_i  (sy_neg_q),
    .pos_o     (pos_next),
    .flags_o   (flags)
  );

  // deltas and initial error from the captured end points
  assign dx_calc  = (end_x_q > pos_q.x) ? (end_x_q - pos_q.x) : (pos_q.x - end_x_q);
  assign dy_calc  = (end_y_q > pos_q.y) ? (end_y_q - pos_q.y) : (pos_q.y - end_y_q);
  assign err_init = $signed({{(ERR_WIDTH-COORD_WIDTH){1'b0}}, dx_calc})
                  - $signed({{(ERR_WIDTH-COORD_WIDTH){1'b0}}, dy_calc});

  // screen row in modular arithmetic
  assign row_diff = DIFF_WIDTH'(height_q) - DIFF_WIDTH'(pos_q.y);

  assign out_free    = !out_valid_q || out_ready_i;
  assign walk_done   = flags.hit || flags.at_end;
  assign result_load = (state_q == S_WALK) && walk_done && out_free;

  // sequencer, walk registers and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      height_q    <= HEIGHT_RESET;
      pos_q       <= '0;
      end_x_q     <= '0;
      end_y_q     <= '0;
      probe_q     <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      sx_neg_q    <= 1'b0;
      sy_neg_q    <= 1'b0;
      found_q     <= 1'b0;
      point_y_q   <= '0;
      row_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        height_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i && !result_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            pos_q.x   <= start_x_i;
            pos_q.y   <= start_y_i;
            pos_q.err <= '0;
            end_x_q   <= end_x_i;
            end_y_q   <= end_y_i;
            probe_q   <= probe_x_i;
            state_q   <= S_SETUP;
          end
        end
        S_SETUP: begin
          dx_q      <= dx_calc;
          dy_q      <= dy_calc;
          sx_neg_q  <= !(pos_q.x < end_x_q);
          sy_neg_q  <= !(pos_q.y < end_y_q);
          pos_q.err <= err_init;
          state_q   <= S_WALK;
        end
        S_WALK: begin
          if (walk_done) begin
            // hold the final point until the result register frees up
            if (out_free) begin
              out_valid_q <= 1'b1;
              found_q     <= flags.hit;
              point_y_q   <= flags.hit ? pos_q.y : '0;
              row_q       <= flags.hit ? $signed(row_diff[ROW_WIDTH-1:0]) : '0;
              state_q     <= S_IDLE;
            end
          end else begin
            pos_q <= pos_next;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign point_y_o    = point_y_q;
  assign screen_row_o = row_q;

  // a miss reports zeros
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (point_y_o == '0 && screen_row_o == '0))
    else $error("miss result carries nonzero payload");

  // an accepted item keeps the input blocked through setup and into the walk state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!in_ready_o ##1 !in_ready_o))
    else $error("input ready during setup");

  // a result is loaded only when the walk stopped on the probe column or end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && !walk_done) |=> (state_q == S_WALK && !$rose(out_valid_q)))
    else $error("walk left early");

  // the walk point does not move once a stop condition is seen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && walk_done && !out_free) |=> (state_q == S_WALK && $stable(pos_q)))
    else $error("walk moved while stalled on result");

endmodule
